### rtl/core/bmpp_pkg.sv
// Package for the bitmap pixel depth packer: format codes, register indexes,
// constants and the byte burst type shared by the core and its pixel unit.
// No dependencies.
package bmpp_pkg;

  localparam int MAX_WIDTH_DEF = 4096;
  localparam int WIDTH_W       = 13;
  localparam int FMT_W         = 2;
  localparam int CFG_IDX_W     = 1;
  localparam int CFG_DATA_W    = WIDTH_W;

  localparam logic [CFG_IDX_W-1:0] CFG_OUT_FORMAT  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH = 1'd1;

  localparam logic [FMT_W-1:0]   FMT_RESET      = 2'd1;
  localparam logic [WIDTH_W-1:0] WIDTH_RESET    = 13'd1;

  localparam logic [7:0]  GRAY_THRESHOLD = 8'd125;
  localparam logic [10:0] DIV3_RECIP     = 11'd683;
  localparam int          DIV3_SHIFT     = 11;

  // Bytes caused by one pixel: up to three data bytes followed by padding.
  typedef struct packed {
    logic [2:0][7:0] data;
    logic [1:0]      n_data;
    logic [2:0]      n_total;
  } burst_t;

endpackage

### rtl/core/bmpp_if.sv
// Valid/ready channel interfaces for the bitmap pixel depth packer.
// Depends on nothing; one interface for pixels and one for row bytes.
interface bmpp_pixel_if;
  logic       valid;
  logic       ready;
  logic [7:0] blue;
  logic [7:0] green;
  logic [7:0] red;

  modport source (output valid, output blue, output green, output red, input ready);
  modport sink   (input valid, input blue, input green, input red, output ready);
endinterface

interface bmpp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       is_padding;
  logic       last_of_item;

  modport source (output valid, output out_byte, output is_padding, output last_of_item,
                  input ready);
  modport sink   (input valid, input out_byte, input is_padding, input last_of_item,
                  output ready);
endinterface

### rtl/core/bitmap_pixel_depth_packer.sv
// Bitmap pixel depth packer: converts BGR pixels into bitmap row bytes at
// 1, 8 or 24 bits per pixel. Depends on bmpp_pkg, bmpp_if and bmpp_pixel_unit.
//
// Pixels enter an input register; the pixel unit turns each one into a burst
// of up to six bytes (data, then row padding), which a byte sequencer hands
// to the output register at one byte per clock unless the output stalls.
// The output port is thus the limiting resource: a pixel gives one byte in
// 8bpp, three in 24bpp and in 1bpp one only when it fills a byte or ends the
// row, plus up to three padding bytes at a row end. A pixel's bytes pass the
// input, burst and output registers in turn. A configuration write restarts
// the row and should be made only when the block is empty.
module bitmap_pixel_depth_packer import bmpp_pkg::*; #(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  bmpp_pixel_if.sink            in_px,
  bmpp_byte_if.source           out_bt,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  logic [FMT_W-1:0]   fmt_r;
  logic [WIDTH_W-1:0] width_r;
  logic               restart;

  logic       in_v_r;
  logic [7:0] blue_r, green_r, red_r;
  logic       adv;

  burst_t     burst_nxt, burst_r;
  logic [2:0] bcnt_r, bpos_r;
  logic       pop, burst_free;

  logic       out_v_r, pad_r, last_r;
  logic [7:0] byte_r;
  logic [7:0] byte_nxt;
  logic       pad_nxt;

  assign restart = cfg_we && (cfg_index == CFG_OUT_FORMAT || cfg_index == CFG_IMAGE_WIDTH);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fmt_r   <= FMT_RESET;
      width_r <= WIDTH_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_OUT_FORMAT:  fmt_r   <= cfg_wdata[FMT_W-1:0];
        CFG_IMAGE_WIDTH: width_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign pop        = (bcnt_r != 3'd0) && (!out_v_r || out_bt.ready);
  assign burst_free = (bcnt_r == 3'd0) || (bcnt_r == 3'd1 && pop);
  assign adv        = in_v_r && burst_free;
  assign in_px.ready = !in_v_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_px.ready) begin
      in_v_r <= in_px.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_px.ready && in_px.valid) begin
      blue_r  <= in_px.blue;
      green_r <= in_px.green;
      red_r   <= in_px.red;
    end
  end

  bmpp_pixel_unit #(
    .MAX_WIDTH(MAX_WIDTH)
  ) u_pixel (
    .clk        (clk),
    .rst_n      (rst_n),
    .restart    (restart),
    .advance    (adv),
    .out_format (fmt_r),
    .image_width(width_r),
    .blue       (blue_r),
    .green      (green_r),
    .red        (red_r),
    .burst      (burst_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bcnt_r <= '0;
      bpos_r <= '0;
    end else if (adv) begin
      bcnt_r <= burst_nxt.n_total;
      bpos_r <= '0;
    end else if (pop) begin
      bcnt_r <= bcnt_r - 3'd1;
      bpos_r <= bpos_r + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      burst_r <= burst_nxt;
    end
  end

  assign pad_nxt  = bpos_r >= {1'b0, burst_r.n_data};
  assign byte_nxt = pad_nxt ? 8'h00 : burst_r.data[bpos_r[1:0]];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (pop) begin
      out_v_r <= 1'b1;
    end else if (out_bt.ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      byte_r <= byte_nxt;
      pad_r  <= pad_nxt;
      last_r <= (bcnt_r == 3'd1);
    end
  end

  assign out_bt.valid        = out_v_r;
  assign out_bt.out_byte     = byte_r;
  assign out_bt.is_padding   = pad_r;
  assign out_bt.last_of_item = last_r;

  a_burst_bound: assert property (@(posedge clk) disable iff (!rst_n)
    bcnt_r <= 3'd6)
    else $error("burst count beyond six bytes");

  a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && pad_r |-> byte_r == 8'h00)
    else $error("padding byte is not zero");

  a_empty_takes: assert property (@(posedge clk) disable iff (!rst_n)
    bcnt_r == 3'd0 |-> in_px.ready)
    else $error("input stalled while no burst is pending");

  a_last_reload: assert property (@(posedge clk) disable iff (!rst_n)
    pop && bcnt_r == 3'd1 && !adv |=> bcnt_r == 3'd0 && out_v_r && last_r)
    else $error("final byte of a transaction not marked");

endmodule

### rtl/core/bmpp_pixel_unit.sv
// Row state and per-pixel conversion: gray value, 1bpp bit packing and
// row end padding. Depends on bmpp_pkg.
module bmpp_pixel_unit import bmpp_pkg::*; #(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               restart,
  input  logic               advance,
  input  logic [FMT_W-1:0]   out_format,
  input  logic [WIDTH_W-1:0] image_width,
  input  logic [7:0]         blue,
  input  logic [7:0]         green,
  input  logic [7:0]         red,
  output burst_t             burst
);

  localparam int CNT_W = $clog2(MAX_WIDTH);
  localparam int CMP_W = ((CNT_W > WIDTH_W) ? CNT_W : WIDTH_W) + 1;
  localparam logic [CMP_W-1:0] MAX_W_C = CMP_W'(MAX_WIDTH);

  logic [CNT_W-1:0]   col_r, col_nxt;
  logic [7:0]         acc_r, acc_nxt;
  logic [2:0]         bpos_r, bpos_nxt;
  logic [WIDTH_W-1:0] eff_w;
  logic               row_end;
  logic [9:0]         sum;
  logic [20:0]        prod;
  logic [7:0]         gray;
  logic [7:0]         acc_set;
  logic [1:0]         row_low;
  logic [WIDTH_W-1:0] w_plus7;
  logic [1:0]         pad;

  always_comb begin
    if (image_width == '0) begin
      eff_w = WIDTH_W'(1);
    end else if ({{(CMP_W-WIDTH_W){1'b0}}, image_width} > MAX_W_C) begin
      eff_w = MAX_W_C[WIDTH_W-1:0];
    end else begin
      eff_w = image_width;
    end
  end

  assign row_end = ({{(CMP_W-CNT_W){1'b0}}, col_r} + CMP_W'(1))
                   >= {{(CMP_W-WIDTH_W){1'b0}}, eff_w};

  assign sum  = {2'b00, blue} + {2'b00, green} + {2'b00, red};
  assign prod = {11'd0, sum} * {10'd0, DIV3_RECIP};
  assign gray = prod[DIV3_SHIFT +: 8];

  assign acc_set = acc_r | ((gray > GRAY_THRESHOLD) ? (8'h80 >> bpos_r) : 8'h00);
  assign w_plus7 = eff_w + WIDTH_W'(7);

  always_comb begin
    burst    = '0;
    acc_nxt  = acc_r;
    bpos_nxt = bpos_r;
    if (out_format[1]) begin
      burst.data   = {red, green, blue};
      burst.n_data = 2'd3;
      row_low      = eff_w[1:0] + {eff_w[0], 1'b0};
    end else if (out_format[0]) begin
      burst.data[0] = gray;
      burst.n_data  = 2'd1;
      row_low       = eff_w[1:0];
    end else begin
      row_low = w_plus7[4:3];
      if (bpos_r == 3'd7 || row_end) begin
        burst.data[0] = acc_set;
        burst.n_data  = 2'd1;
        acc_nxt       = '0;
        bpos_nxt      = '0;
      end else begin
        acc_nxt  = acc_set;
        bpos_nxt = bpos_r + 3'd1;
      end
    end
    pad           = row_end ? (2'd0 - row_low) : 2'd0;
    burst.n_total = {1'b0, burst.n_data} + {1'b0, pad};
    col_nxt       = row_end ? '0 : col_r + CNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n || restart) begin
      col_r  <= '0;
      acc_r  <= '0;
      bpos_r <= '0;
    end else if (advance) begin
      col_r  <= col_nxt;
      acc_r  <= acc_nxt;
      bpos_r <= bpos_nxt;
    end
  end

endmodule

### test/tb_bitmap_pixel_depth_packer.sv
// Testbench for bitmap_pixel_depth_packer: a directed table, then random pixels,
// checked byte by byte against the table's bytes or a predictor held here.
// Depends on bmpp_pkg, bmpp_if and the RTL of the block.
`timescale 1ns / 1ps

module tb_bitmap_pixel_depth_packer import bmpp_pkg::*; ();

  localparam logic [FMT_W-1:0] FMT_1BPP      = 2'd0;
  localparam logic [FMT_W-1:0] FMT_8BPP      = 2'd1;
  localparam logic [FMT_W-1:0] FMT_24BPP     = 2'd2;
  localparam logic [FMT_W-1:0] FMT_24BPP_ALT = 2'd3;
  localparam logic [FMT_W-1:0] PHASE_FMT [4] = '{FMT_1BPP, FMT_8BPP, FMT_24BPP, FMT_24BPP_ALT};

  localparam int SETTLE_CYCLES = 8;
  localparam int HOLD_CYCLES   = 200;
  localparam int STALL_LIMIT   = 2000;
  localparam int PHASE_PIXELS  = 24;

  typedef enum logic { ROW_WRITE, ROW_PIXEL } row_kind_e;
  typedef enum int { IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH } idle_mode_e;

  typedef struct packed {
    row_kind_e             kind;
    logic [CFG_IDX_W-1:0]  reg_index;
    logic [CFG_DATA_W-1:0] reg_value;
    logic [7:0]            blue;
    logic [7:0]            green;
    logic [7:0]            red;
    logic                  typed;
    logic [1:0]            n_data;
    logic [7:0]            d0;
    logic [7:0]            d1;
    logic [7:0]            d2;
    logic [1:0]            n_pad;
  } stim_row_t;

  typedef struct packed {
    logic [7:0] value;
    logic       is_pad;
    logic       is_last;
  } row_byte_t;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  bmpp_pixel_if px_if ();
  bmpp_byte_if  bt_if ();

  bitmap_pixel_depth_packer i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_px     (px_if),
    .out_bt    (bt_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  stim_row_t directed_rows [33] = '{
    '{ROW_PIXEL, '0, 13'd0, 8'h00, 8'h00, 8'h00, 1'b1, 2'd1, 8'h00, 8'h00, 8'h00, 2'd3},
    '{ROW_PIXEL, '0, 13'd0, 8'hff, 8'hff, 8'hff, 1'b1, 2'd1, 8'hff, 8'h00, 8'h00, 2'd3},
    '{ROW_PIXEL, '0, 13'd0, 8'h01, 8'h02, 8'h04, 1'b1, 2'd1, 8'h02, 8'h00, 8'h00, 2'd3},
    '{ROW_WRITE, CFG_OUT_FORMAT, 13'(FMT_24BPP), 8'h00, 8'h00, 8'h00,
      1'b0, 2'd0, 8'h00, 8'h00, 8'h00, 2'd0},
    '{ROW_PIXEL, '0, 13'd0, 8'h12, 8'h34, 8'h56, 1'b1, 2'd3, 8'h12, 8'h34, 8'h56, 2'd1},
    '{ROW_WRITE, CFG_OUT_FORMAT, 13'(FMT_24BPP_ALT), 8'h00, 8'h00, 8'h00,
      1'b0, 2'd0, 8'h00, 8'h00, 8'h00, 2'd0},
    '{ROW_PIXEL, '0, 13'd0, 8'hff, 8'h00, 8'h80, 1'b1, 2'd3, 8'hff, 8'h00, 8'h80, 2'd1},
    '{ROW_WRITE, CFG_OUT_FORMAT, 13'(FMT_1BPP), 8'h00, 8'h00, 8'h00,
      1'b0, 2'd0, 8'h00, 8'h00, 8'h00, 2'd0},
    '{ROW_PIXEL, '0, 13'd0, 8'h7e, 8'h7e, 8'h7e, 1'b1, 2'd1, 8'h80, 8'h00, 8'h00, 2'd3},
    '{ROW_PIXEL, '0, 13'd0, 8'h7d, 8'h7d, 8'h7d, 1'b1, 2'd1, 8'h00, 8'h00, 8'h00, 2'd3},
    '{ROW_PIXEL, '0, 13'd0, 8'h7c, 8'h7e, 8'h7f, 1'b1, 2'd1, 8'h00, 8'h00, 8'h00, 2'd3},
    '{ROW_PIXEL, '0, 13'd0, 8'h7d, 8'h7e, 8'h7f, 1'b1, 2'd1, 8'h80, 8'h00, 8'h00, 2'd3},
    '{ROW_WRITE, CFG_IMAGE_WIDTH, 13'd0, 8'h00, 8'h00, 8'h00,
      1'b0, 2'd0, 8'h00, 8'h00, 8'h00, 2'd0},
    '{ROW_PIXEL, '0, 13'd0, 8'hff, 8'hff, 8'hff, 1'b1, 2'd1, 8'h80, 8'h00, 8'h00, 2'd3},
    '{ROW_WRITE, CFG_IMAGE_WIDTH, 13'd10, 8'h00, 8'h00, 8'h00,
      1'b0, 2'd0, 8'h00, 8'h00, 8'h00, 2'd0},
    '{ROW_PIXEL, '0, 13'd0, 8'hc8, 8'hc8, 8'hc8, 1'b0, 2'd0, 8'h00, 8'h00, 8'h00, 2'd0},
    '{ROW_PIXEL, '0, 13'd0, 8'h00, 8'h00, 8'h00, 1'b0, 2'd0, 8'h00, 8'h00, 8'h00, 2'd0},
    '{ROW_PIXEL, '0, 13'd0, 8'hff, 8'hff, 8'hff, 1'b0, 2'd0, 8'h00, 8'h00, 8'h00, 2'd0},
    '{ROW_WRITE, CFG_IMAGE_WIDTH, 13'd10, 8'h00, 8'h00, 8'h00,
      1'b0, 2'd0, 8'h00, 8'h00, 8'h00, 2'd0},
    '{ROW_PIXEL, '0, 13'd0, 8'hff, 8'hff, 8'hff, 1'b0, 2'd0, 8'h00, 8'h00, 8'h00, 2'd0},
    '{ROW_PIXEL, '0, 13'd0, 8'h00, 8'h00, 8'h00, 1'b0, 2'd0, 8'h00, 8'h00, 8'h00, 2'd0},
    '{ROW_PIXEL, '0, 13'd0, 8'h80, 8'h80, 8'h80, 1'b0, 2'd0, 8'h00, 8'h00, 8'h00, 2'd0},
    '{ROW_PIXEL, '0, 13'd0, 8'h7d, 8'h7d, 8'h7d, 1'b0, 2'd0, 8'h00, 8'h00, 8'h00, 2'd0},
    '{ROW_PIXEL, '0, 13'd0, 8'hff, 8'hff, 8'hff, 1'b0, 2'd0, 8'h00, 8'h00, 8'h00, 2'd0},
    '{ROW_PIXEL, '0, 13'd0, 8'h00, 8'h00, 8'h00, 1'b0, 2'd0, 8'h00, 8'h00, 8'h00, 2'd0},
    '{ROW_PIXEL, '0, 13'd0, 8'hff, 8'h00, 8'hff, 1'b0, 2'd0, 8'h00, 8'h00, 8'h00, 2'd0},
    '{ROW_PIXEL, '0, 13'd0, 8'h00, 8'hff, 8'h00, 1'b0, 2'd0, 8'h00, 8'h00, 8'h00, 2'd0},
    '{ROW_PIXEL, '0, 13'd0, 8'hff, 8'hff, 8'hff, 1'b0, 2'd0, 8'h00, 8'h00, 8'h00, 2'd0},
    '{ROW_PIXEL, '0, 13'd0, 8'h00, 8'h00, 8'hff, 1'b0, 2'd0, 8'h00, 8'h00, 8'h00, 2'd0},
    '{ROW_WRITE, CFG_OUT_FORMAT, 13'(FMT_8BPP), 8'h00, 8'h00, 8'h00,
      1'b0, 2'd0, 8'h00, 8'h00, 8'h00, 2'd0},
    '{ROW_WRITE, CFG_IMAGE_WIDTH, 13'd8191, 8'h00, 8'h00, 8'h00,
      1'b0, 2'd0, 8'h00, 8'h00, 8'h00, 2'd0},
    '{ROW_PIXEL, '0, 13'd0, 8'ha5, 8'h5a, 8'hc3, 1'b0, 2'd0, 8'h00, 8'h00, 8'h00, 2'd0},
    '{ROW_PIXEL, '0, 13'd0, 8'h3c, 8'h96, 8'he1, 1'b0, 2'd0, 8'h00, 8'h00, 8'h00, 2'd0}
  };

  logic [FMT_W-1:0]   pred_format;
  logic [WIDTH_W-1:0] pred_width;
  logic [11:0]        pred_column;
  logic [7:0]         pred_acc;
  logic [2:0]         pred_bitpos;
  row_byte_t          burst [6];
  row_byte_t          pending_bytes [$];

  stim_row_t   px_row;
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned hold_asks;
  int unsigned quiet_cycles = 0;
  int unsigned mismatch_count = 0;

  // Fills burst with the bytes that one pixel causes and returns their count.
  function automatic int pack_pixel(input logic [7:0] b, input logic [7:0] g,
                                    input logic [7:0] r);
    int unsigned eff;
    int unsigned gray;
    int unsigned row_len;
    int unsigned pad_left;
    bit          row_end;
    int          n;
    eff = (pred_width == 0) ? 1 : (pred_width > MAX_WIDTH_DEF) ? MAX_WIDTH_DEF : pred_width;
    gray = (int'(b) + int'(g) + int'(r)) / 3;
    row_end = (int'(pred_column) + 1) >= eff;
    n = 0;
    if (pred_format == FMT_24BPP || pred_format == FMT_24BPP_ALT) begin
      burst[0] = '{b, 1'b0, 1'b0};
      burst[1] = '{g, 1'b0, 1'b0};
      burst[2] = '{r, 1'b0, 1'b0};
      n = 3;
      row_len = 3 * eff;
    end else if (pred_format == FMT_8BPP) begin
      burst[0] = '{gray[7:0], 1'b0, 1'b0};
      n = 1;
      row_len = eff;
    end else begin
      if (gray > GRAY_THRESHOLD) pred_acc[3'd7 - pred_bitpos] = 1'b1;
      pred_bitpos = pred_bitpos + 3'd1;
      if (pred_bitpos == 3'd0 || row_end) begin
        burst[0] = '{pred_acc, 1'b0, 1'b0};
        n = 1;
        pred_acc = '0;
        pred_bitpos = '0;
      end
      row_len = (eff + 7) / 8;
    end
    if (row_end) begin
      pad_left = (4 - (row_len % 4)) % 4;
      while (pad_left > 0) begin
        burst[n] = '{8'h00, 1'b1, 1'b0};
        n++;
        pad_left--;
      end
      pred_column = '0;
    end else begin
      pred_column = pred_column + 12'd1;
    end
    if (n > 0) burst[n-1].is_last = 1'b1;
    return n;
  endfunction

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin : monitor
    int        n_out;
    int        n_typed;
    row_byte_t want;
    if (!rst_n) begin
      pred_format = FMT_RESET;
      pred_width  = WIDTH_RESET;
      pred_column = '0;
      pred_acc    = '0;
      pred_bitpos = '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_OUT_FORMAT:  pred_format = cfg_wdata[FMT_W-1:0];
          CFG_IMAGE_WIDTH: pred_width  = cfg_wdata;
          default: ;
        endcase
        pred_column = '0;
        pred_acc    = '0;
        pred_bitpos = '0;
      end
      if (px_if.valid && px_if.ready) begin
        n_out = pack_pixel(px_if.blue, px_if.green, px_if.red);
        if (px_row.typed) begin
          n_typed = int'(px_row.n_data) + int'(px_row.n_pad);
          for (int k = 0; k < n_typed; k++) begin
            want.value = (k >= px_row.n_data) ? 8'h00 :
                         (k == 0) ? px_row.d0 : (k == 1) ? px_row.d1 : px_row.d2;
            want.is_pad  = (k >= px_row.n_data);
            want.is_last = (k == n_typed - 1);
            pending_bytes.push_back(want);
          end
        end else begin
          for (int k = 0; k < n_out; k++) pending_bytes.push_back(burst[k]);
        end
      end
      if (bt_if.valid && bt_if.ready) begin
        if (pending_bytes.size() == 0) begin
          $display("%0t: unexpected byte %02h pad %0b last %0b", $time,
                   bt_if.out_byte, bt_if.is_padding, bt_if.last_of_item);
          mismatch_count++;
        end else begin
          want = pending_bytes.pop_front();
          if (bt_if.out_byte !== want.value || bt_if.is_padding !== want.is_pad ||
              bt_if.last_of_item !== want.is_last) begin
            $display("%0t: expected byte %02h pad %0b last %0b, got byte %02h pad %0b last %0b",
                     $time, want.value, want.is_pad, want.is_last,
                     bt_if.out_byte, bt_if.is_padding, bt_if.last_of_item);
            mismatch_count++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin : watchdog
    if ((px_if.valid && px_if.ready) || (bt_if.valid && bt_if.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles == STALL_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin : receiver
    int unsigned hold_left;
    int unsigned hold_seen;
    hold_left = 0;
    hold_seen = 0;
    bt_if.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_asks != hold_seen) begin
        hold_seen = hold_asks;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        bt_if.ready <= 1'b0;
      end else begin
        bt_if.ready <= (recv_stall_pct == 0) || ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  task automatic drain_bytes();
    px_if.valid <= 1'b0;
    @(posedge clk);
    while (pending_bytes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    drain_bytes();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic send_pixel(input stim_row_t row);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      px_if.valid <= 1'b0;
      @(posedge clk);
    end
    px_if.valid <= 1'b1;
    px_if.blue  <= row.blue;
    px_if.green <= row.green;
    px_if.red   <= row.red;
    px_row      <= row;
    do @(posedge clk); while (!px_if.ready);
  endtask

  task automatic set_idling(input idle_mode_e mode);
    send_idle_pct  = (mode == IDLE_SEND) ? 61 : (mode == IDLE_BOTH) ? 32 : 0;
    recv_stall_pct <= (mode == IDLE_RECV) ? 61 : (mode == IDLE_BOTH) ? 32 : 0;
  endtask

  initial begin : stimulus
    stim_row_t          row;
    logic [WIDTH_W-1:0] width;
    int unsigned        base;
    rst_n          = 1'b0;
    cfg_we         = 1'b0;
    cfg_index      = '0;
    cfg_wdata      = '0;
    px_if.valid    = 1'b0;
    px_if.blue     = '0;
    px_if.green    = '0;
    px_if.red      = '0;
    px_row         = '0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_asks      = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_WRITE) begin
        write_reg(directed_rows[i].reg_index, directed_rows[i].reg_value);
      end else begin
        send_pixel(directed_rows[i]);
      end
    end

    for (int ph = 0; ph < 8; ph++) begin
      width = (ph == 0) ? 13'd1 : (ph == 3) ? 13'd0 : (ph == 5) ? 13'd4096 :
              13'($urandom_range(2, 19));
      write_reg(CFG_OUT_FORMAT, 13'(PHASE_FMT[ph % 4]));
      write_reg(CFG_IMAGE_WIDTH, width);
      set_idling(idle_mode_e'((ph / 2) % 4));
      repeat (PHASE_PIXELS) begin
        row = '0;
        row.kind = ROW_PIXEL;
        if ($urandom_range(1) == 1) begin
          // Near the white threshold, where the floor division decides the bit.
          base = $urandom_range(118, 133);
          row.blue  = 8'(base + $urandom_range(4) - 2);
          row.green = 8'(base + $urandom_range(4) - 2);
          row.red   = 8'(base + $urandom_range(4) - 2);
        end else begin
          row.blue  = 8'($urandom);
          row.green = 8'($urandom);
          row.red   = 8'($urandom);
        end
        send_pixel(row);
      end
    end

    // The receiver holds off for a long stretch so that the input backs up.
    set_idling(IDLE_NONE);
    write_reg(CFG_OUT_FORMAT, 13'(FMT_24BPP));
    write_reg(CFG_IMAGE_WIDTH, 13'd5);
    hold_asks <= hold_asks + 1;
    repeat (40) begin
      row = '0;
      row.kind  = ROW_PIXEL;
      row.blue  = 8'($urandom);
      row.green = 8'($urandom);
      row.red   = 8'($urandom);
      send_pixel(row);
    end

    drain_bytes();
    if (mismatch_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
